// File: src/rpg_pkg.sv
// Shared widths, register indexes and types for the rim proximity grip detector.
package rpg_pkg;

    // Field and register widths
    localparam int POS_W      = 18;
    localparam int MAG_W      = 18;
    localparam int REG_W      = 16;
    localparam int DIST_W     = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int EXTRA_BITS = 8;

    // Datapath widths
    localparam int SQ_W   = 36;            // sum of two 18-bit squares
    localparam int OFF_W  = 26;            // rim offset with extra fraction bits
    localparam int PROD_W = 2 * OFF_W;     // shared multiplier output
    localparam int RAD_W  = 54;            // square root radicand
    localparam int ROOT_W = RAD_W / 2;     // square root result
    localparam int CNT_W  = 5;             // iteration counter, holds ROOT_W - 1

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_PRESENT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_AXIS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIM_RADIUS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENTER_DISTANCE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DISTANCE = 3'd4;

    // Spin axis codes
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Status of the shared square root unit
    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_status_t;

endpackage

// File: src/rpg_isqrt.sv
// Iterative integer square root, one result bit per cycle.
module rpg_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rpg_pkg::RAD_W-1:0]  radicand,
    output rpg_pkg::sqrt_status_t      status,
    output logic [rpg_pkg::ROOT_W-1:0] root
);
    import rpg_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    // Bring down the next radicand bit pair and form the trial divisor
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_reg[ROOT_W-2:0], 2'b01};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ROOT_W - 1);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign root        = root_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("square root done held longer than one cycle");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("square root done without a finished iteration");

    a_busy_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !done_reg)
        else $error("square root done while still iterating");

endmodule

// File: src/rim_proximity_grip_detector_top.sv
// Top level: sequencer, shared multiplier, grip state and result register.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------------
//  input    | in_valid / in_stall       | hand_sel, tracker_valid, hand_tracked,
//           |                           | palm_present, pos_x, pos_y, pos_z
//  output   | out_valid / out_stall     | hand_out, grip, grip_changed, distance_valid,
//           |                           | rim_distance
//  config   | cfg_wr_en                 | cfg_index, cfg_data
//
//  A measured item runs through four multiplier passes, two waits on the shared root unit
//  (27 iterations each) and the other sequencer steps S_ROOT1, S_OFFS, S_ROOT2 and S_FIN
//  before its result loads; the next item can be accepted in the cycle after that load.
//  A forced or held item goes from idle straight to S_FIN, where its result loads.
//  in_stall is high whenever the sequencer is not idle.
//  Reset clears both grip bits to released and loads the register reset values.
//  A stalled result holds in the output register; the next item finishes behind it
//  and waits in its final step until the register is free.
module rim_proximity_grip_detector_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpg_pkg::REG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           hand_sel,
    input  logic                           tracker_valid,
    input  logic                           hand_tracked,
    input  logic                           palm_present,
    input  logic signed [rpg_pkg::POS_W-1:0] pos_x,
    input  logic signed [rpg_pkg::POS_W-1:0] pos_y,
    input  logic signed [rpg_pkg::POS_W-1:0] pos_z,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           hand_out,
    output logic                           grip,
    output logic                           grip_changed,
    output logic                           distance_valid,
    output logic [rpg_pkg::DIST_W-1:0]     rim_distance
);
    import rpg_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ_A  = 4'd1;
    localparam logic [3:0] S_SQ_B  = 4'd2;
    localparam logic [3:0] S_SQ_C  = 4'd3;
    localparam logic [3:0] S_ROOT1 = 4'd4;
    localparam logic [3:0] S_WAIT1 = 4'd5;
    localparam logic [3:0] S_OFFS  = 4'd6;
    localparam logic [3:0] S_OFFSQ = 4'd7;
    localparam logic [3:0] S_ROOT2 = 4'd8;
    localparam logic [3:0] S_WAIT2 = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    // Configuration registers
    logic             wheel_reg;
    logic [1:0]       axis_reg;
    logic [REG_W-1:0] radius_reg;
    logic [REG_W-1:0] enter_reg;
    logic [REG_W-1:0] release_reg;

    // Sequencer and sample registers
    logic [3:0]       state_reg, state_next;
    logic [1:0]       grip_reg, grip_next;
    logic             hand_reg, tracker_reg, tracked_reg, palm_reg;
    logic [POS_W-1:0] px_reg, py_reg, pz_reg;
    logic [SQ_W-1:0]  acc_reg, acc_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [OFF_W-1:0] off_reg, off_next;

    // Result register
    logic              out_valid_reg, out_valid_next;
    logic              hand_out_reg, grip_out_reg, changed_reg, dvalid_reg;
    logic [DIST_W-1:0] dist_reg;

    // Datapath wires
    logic [MAG_W-1:0]  mag_x, mag_y, mag_z;
    logic [MAG_W-1:0]  axial, rad1, rad2;
    logic [OFF_W-1:0]  mul_a;
    logic              sq_start;
    logic [RAD_W-1:0]  sq_radicand;
    sqrt_status_t      sq_stat;
    logic [ROOT_W-1:0] sq_root;
    logic [ROOT_W-1:0] radius_q;
    logic [ROOT_W-1:0] off_wide;
    logic [ROOT_W:0]   dq_round;
    logic [ROOT_W-EXTRA_BITS:0] dist_wide;
    logic              out_free;
    logic              load_out;
    logic              cur_grip, new_grip, new_dvalid;
    logic [DIST_W-1:0] new_dist;
    logic              in_accept;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_reg   <= 1'b0;
            axis_reg    <= 2'd0;
            radius_reg  <= REG_W'(288);
            enter_reg   <= REG_W'(80);
            release_reg <= REG_W'(128);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_WHEEL_PRESENT:    wheel_reg   <= cfg_data[0];
                REG_SPIN_AXIS:        axis_reg    <= cfg_data[1:0];
                REG_RIM_RADIUS:       radius_reg  <= cfg_data;
                REG_ENTER_DISTANCE:   enter_reg   <= cfg_data;
                REG_RELEASE_DISTANCE: release_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Take magnitudes and split axial from radial components
    assign mag_x = px_reg[POS_W-1] ? MAG_W'(-px_reg) : px_reg;
    assign mag_y = py_reg[POS_W-1] ? MAG_W'(-py_reg) : py_reg;
    assign mag_z = pz_reg[POS_W-1] ? MAG_W'(-pz_reg) : pz_reg;

    always_comb
    begin
        case (axis_reg)
            AXIS_Y:
            begin
                axial = mag_y;
                rad1  = mag_x;
                rad2  = mag_z;
            end
            AXIS_Z:
            begin
                axial = mag_z;
                rad1  = mag_x;
                rad2  = mag_y;
            end
            default:
            begin
                axial = mag_x;
                rad1  = mag_y;
                rad2  = mag_z;
            end
        endcase
    end

    // Select the operand of the shared squaring multiplier
    always_comb
    begin
        case (state_reg)
            S_SQ_A:  mul_a = OFF_W'(rad1);
            S_SQ_B:  mul_a = OFF_W'(rad2);
            S_SQ_C:  mul_a = OFF_W'(axial);
            default: mul_a = off_reg;
        endcase
    end

    // Rim offset from the radial length, both with extra fraction bits
    assign radius_q = ROOT_W'({radius_reg, {EXTRA_BITS{1'b0}}});
    assign off_wide = (sq_root >= radius_q) ? (sq_root - radius_q) : (radius_q - sq_root);

    // Drive the shared square root unit
    assign sq_start    = (state_reg == S_ROOT1) || (state_reg == S_ROOT2);
    assign sq_radicand = (state_reg == S_ROOT1)
                       ? RAD_W'({acc_reg, {(2 * EXTRA_BITS){1'b0}}})
                       : RAD_W'(prod_reg) + RAD_W'({acc_reg, {(2 * EXTRA_BITS){1'b0}}});

    rpg_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_radicand),
        .status   (sq_stat),
        .root     (sq_root)
    );

    // Round and saturate the distance, then apply hysteresis
    assign dq_round  = {1'b0, sq_root} + (ROOT_W + 1)'(1 << (EXTRA_BITS - 1));
    assign dist_wide = dq_round[ROOT_W:EXTRA_BITS];
    assign cur_grip  = grip_reg[hand_reg];

    always_comb
    begin
        new_grip   = cur_grip;
        new_dvalid = 1'b0;
        new_dist   = '0;
        if (!wheel_reg || !tracker_reg)
        begin
            new_grip = 1'b1;
        end
        else if (tracked_reg && palm_reg)
        begin
            new_dvalid = 1'b1;
            if (cur_grip)
                new_grip = !(ROOT_W'(sq_root) > ROOT_W'({release_reg, {EXTRA_BITS{1'b0}}}));
            else
                new_grip = ROOT_W'(sq_root) < ROOT_W'({enter_reg, {EXTRA_BITS{1'b0}}});
            if (dist_wide > (ROOT_W - EXTRA_BITS + 1)'(DIST_MAX))
                new_dist = DIST_MAX;
            else
                new_dist = DIST_W'(dist_wide);
        end
    end

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_out  = (state_reg == S_FIN) && out_free;

    // Step the sequencer
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        off_next   = off_reg;
        grip_next  = grip_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!wheel_reg || !tracker_valid || !hand_tracked || !palm_present)
                        state_next = S_FIN;
                    else
                        state_next = S_SQ_A;
                end
            end
            S_SQ_A:
            begin
                prod_next  = PROD_W'(mul_a * mul_a);
                state_next = S_SQ_B;
            end
            S_SQ_B:
            begin
                acc_next   = prod_reg[SQ_W-1:0];
                prod_next  = PROD_W'(mul_a * mul_a);
                state_next = S_SQ_C;
            end
            S_SQ_C:
            begin
                acc_next   = acc_reg + prod_reg[SQ_W-1:0];
                prod_next  = PROD_W'(mul_a * mul_a);
                state_next = S_ROOT1;
            end
            S_ROOT1:
            begin
                // keep the axial square for the second root
                acc_next   = prod_reg[SQ_W-1:0];
                state_next = S_WAIT1;
            end
            S_WAIT1:
            begin
                if (sq_stat.done)
                    state_next = S_OFFS;
            end
            S_OFFS:
            begin
                off_next   = off_wide[OFF_W-1:0];
                state_next = S_OFFSQ;
            end
            S_OFFSQ:
            begin
                prod_next  = PROD_W'(mul_a * mul_a);
                state_next = S_ROOT2;
            end
            S_ROOT2:
            begin
                state_next = S_WAIT2;
            end
            S_WAIT2:
            begin
                if (sq_stat.done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    grip_next[hand_reg] = new_grip;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Track the result register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (load_out)
            out_valid_next = 1'b1;
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            grip_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            grip_reg      <= grip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the sample and advance the datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            hand_reg    <= hand_sel;
            tracker_reg <= tracker_valid;
            tracked_reg <= hand_tracked;
            palm_reg    <= palm_present;
            px_reg      <= pos_x;
            py_reg      <= pos_y;
            pz_reg      <= pos_z;
        end
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        off_reg  <= off_next;
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            hand_out_reg <= hand_reg;
            grip_out_reg <= new_grip;
            changed_reg  <= new_grip != cur_grip;
            dvalid_reg   <= new_dvalid;
            dist_reg     <= new_dist;
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign hand_out       = hand_out_reg;
    assign grip           = grip_out_reg;
    assign grip_changed   = changed_reg;
    assign distance_valid = dvalid_reg;
    assign rim_distance   = dist_reg;

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        sq_start |-> !sq_stat.busy)
        else $error("square root started while still busy");

    a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        sq_stat.done |-> (state_reg == S_WAIT1) || (state_reg == S_WAIT2))
        else $error("square root finished outside a wait step");

    a_no_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !dvalid_reg |-> dist_reg == '0)
        else $error("distance reported without a measurement");

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !out_valid_reg || !out_stall)
        else $error("result register overwritten while stalled");

endmodule
